>>> design/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
package wbps_pkg;

  localparam int unsigned MAX_PAT = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned LEN_W   = $clog2(MAX_PAT + 1);
  localparam int unsigned PIDX_W  = $clog2(MAX_PAT);
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CIDX_W  = 3;

  localparam logic [7:0] WILDCARD = 8'h2A;

  localparam logic [CIDX_W-1:0] CFG_PAT_LO    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_PAT_HI    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_PAT_LEN   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_START_OFS = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_CODE_END  = 3'd4;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] match_position;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

>>> design/wbps_cell.sv
// One window cell: holds a byte, passes it on, and compares its incoming byte.
module wbps_cell import wbps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_d, byte_q;

  always_comb begin
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end else begin
      byte_d = byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // compare against the byte this cell takes on the shift
  assign hit_o  = !active_i || (pat_byte_i == WILDCARD) || (pat_byte_i == byte_i);
  assign byte_o = byte_q;

endmodule

>>> design/wbps_outbuf.sv
// Two-word result buffer: output register plus skid register.
module wbps_outbuf import wbps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_word_t push_word_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  out_word_t head_d, head_q, skid_d, skid_q;
  logic      head_vld_d, head_vld_q, skid_vld_d, skid_vld_q;
  logic      pop;

  assign pop = head_vld_q && !out_stall_i;

  always_comb begin
    head_d     = head_q;
    skid_d     = skid_q;
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      // full: no push can arrive
      if (pop) begin
        head_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (head_vld_q && !pop) begin
        skid_d     = push_word_i;
        skid_vld_d = 1'b1;
      end else begin
        head_d     = push_word_i;
        head_vld_d = 1'b1;
      end
    end else if (pop) begin
      head_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign out_word_o  = head_q;

endmodule

>>> design/wildcard_byte_pattern_search.sv
// Top level: config registers, position tracking, cell row and result buffer.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid_i/in_stall_o | image_byte, last_byte
//  out     | output    | out_valid_o/out_stall_i | match_found, match_position
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One byte per cycle while in_stall_o is low. All window cells compare in the
// cycle the byte is taken; the result is registered into the output buffer at
// that edge. A two-word output buffer keeps input flowing while a result
// waits; in_stall_o rises only when both buffer words are held.
// Reset clears config, window, position and done flag.
module wildcard_byte_pattern_search import wbps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o
);

  logic [63:0]      pat_lo_q, pat_hi_q;
  logic [LEN_W-1:0] len_q, len_sat;
  logic [POS_W-1:0] start_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
      start_q  <= '0;
      end_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAT_LO:    pat_lo_q <= cfg_wdata_i;
        CFG_PAT_HI:    pat_hi_q <= cfg_wdata_i;
        CFG_PAT_LEN:   len_q    <= cfg_wdata_i[LEN_W-1:0];
        CFG_START_OFS: start_q  <= cfg_wdata_i[POS_W-1:0];
        CFG_CODE_END:  end_q    <= cfg_wdata_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_sat = (len_q > LEN_W'(MAX_PAT)) ? LEN_W'(MAX_PAT) : len_q;

  logic [127:0] pat_all;
  logic [7:0]   pat_bytes [MAX_PAT];

  assign pat_all = {pat_hi_q, pat_lo_q};

  always_comb begin
    for (int k = 0; k < MAX_PAT; k++) begin
      pat_bytes[k] = pat_all[8*k +: 8];
    end
  end

  // search control
  logic              acc, live, done_d, done_q, emit, matched, ended, at_max, len0;
  logic [ADDR_W-1:0] pos_d, pos_q;
  logic [ADDR_W:0]   p1, len_ext, end_ext, start_ext, cand;
  logic [ADDR_W-1:0] cand_pos;
  logic              all_hit, buf_full;
  out_word_t         res_word;
  cell_ctrl_t        cctrl;

  assign acc  = in_valid_i && !in_stall_o;
  assign live = acc && !done_q;

  assign p1        = {1'b0, pos_q} + (ADDR_W+1)'(1);
  assign len_ext   = (ADDR_W+1)'(len_sat);
  assign end_ext   = (ADDR_W+1)'(end_q);
  assign start_ext = (ADDR_W+1)'(start_q);
  assign cand      = p1 - len_ext;
  assign at_max    = (pos_q == '1);
  assign len0      = (len_sat == '0);

  always_comb begin
    if (len0) begin
      matched  = ({1'b0, pos_q} >= start_ext) && ({1'b0, pos_q} <= end_ext);
      ended    = at_max || ({1'b0, pos_q} >= end_ext);
      cand_pos = pos_q;
    end else begin
      matched  = !at_max && (p1 >= len_ext) && (cand >= start_ext) && (p1 <= end_ext)
                 && all_hit;
      ended    = at_max || (p1 >= end_ext);
      cand_pos = cand[ADDR_W-1:0];
    end
  end

  assign emit = live && (matched || ended || in_word_i.last_byte);

  assign res_word.match_found    = matched;
  assign res_word.match_position = matched ? cand_pos[POS_W-1:0] : '1;

  always_comb begin
    done_d = done_q;
    pos_d  = pos_q;
    if (acc && in_word_i.last_byte) begin
      done_d = 1'b0;
      pos_d  = '0;
    end else begin
      if (emit) begin
        done_d = 1'b1;
      end
      if (live && !at_max) begin
        pos_d = p1[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      done_q <= done_d;
      pos_q  <= pos_d;
    end
  end

  assign cctrl.shift = live;
  assign cctrl.clear = acc && in_word_i.last_byte;

  // cell j holds window byte j (0 newest) and checks pattern byte len-1-j
  logic [7:0]       win   [MAX_PAT];
  logic [7:0]       chain [MAX_PAT];
  logic [MAX_PAT-1:0] hits;

  for (genvar j = 0; j < MAX_PAT; j++) begin : g_cell
    logic              active;
    logic [LEN_W-1:0]  pidx;

    if (j == 0) begin : g_head
      assign chain[j] = in_word_i.image_byte;
    end else begin : g_body
      assign chain[j] = win[j-1];
    end

    assign active = len_sat > LEN_W'(j);
    assign pidx   = len_sat - LEN_W'(j) - LEN_W'(1);

    wbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cctrl),
      .byte_i     (chain[j]),
      .pat_byte_i (pat_bytes[pidx[PIDX_W-1:0]]),
      .active_i   (active),
      .byte_o     (win[j]),
      .hit_o      (hits[j])
    );
  end

  assign all_hit = &hits;

  wbps_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_word_i (res_word),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = buf_full;

endmodule

>>> design/wbps_checker.sv
// Port-level checks for the pattern search block, bound to the top level.
module wbps_checker import wbps_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // input back-pressure only comes from a held result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_notfound_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.match_found) |-> (out_word_o.match_position == '1))
    else $error("not-found word without all-ones position");

  // a word only appears after an accepted byte
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && !in_stall_o) && !out_valid_o) |=> !out_valid_o)
    else $error("result word without input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
